>>> design/rcf_pkg.sv
// Shared constants, types and helpers of the radix converter.
// No dependencies; imported by every module of the block.
package rcf_pkg;

  localparam int INT_BITS_DEF     = 40;
  localparam int MAX_FRAC_IN_DEF  = 12;
  localparam int MAX_FRAC_OUT_DEF = 16;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam logic CFG_SRC_BASE = 1'b0;
  localparam logic CFG_DST_BASE = 1'b1;

  localparam logic [4:0] BASE_RESET = 5'd10;
  localparam logic [4:0] BASE_MIN   = 5'd2;
  localparam logic [4:0] BASE_MAX   = 5'd16;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_F    = 8'h46;

  typedef struct packed {
    logic full;
    logic empty;
  } rcf_fifo_stat_t;

  function automatic logic [4:0] clamp_base(input logic [4:0] b);
    logic [4:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  function automatic logic [7:0] to_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CHAR_ZERO + {4'd0, d};
    else c = CHAR_A + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage

>>> design/radix_converter_with_fraction.sv
// Top level of the radix converter: configuration registers, front end,
// job queue and back end. Depends on rcf_pkg, rcf_front, rcf_fifo, rcf_back.
//
// Usage: digits arrive on the in_ ports, one item per clock when start is
// high and busy is low, integer digits first, then fraction digits; in_last
// marks the final digit and in_negative is taken with it. Each finished
// number is queued (two numbers deep); busy is high only while that queue
// is full.
// Results leave on the out_ ports, one per out_valid strobe, most significant
// integer digit first, then fraction digits; out_end_of_run marks the last.
// Each integer digit is found by bit-serial division and later read back
// from the digit store; each fraction digit takes one multiply and four
// shift-subtract steps. An error number yields a single item in the cycle
// after it leaves the queue.
// The receiver cannot stall: every strobe is one taken item.
// cfg_we writes register cfg_index (0 source base, 1 destination base);
// write only while idle. Synchronous reset sets both bases to 10 and clears
// accumulators and queue; no clearing pass is needed.
module radix_converter_with_fraction #(
  parameter int INT_BITS     = rcf_pkg::INT_BITS_DEF,
  parameter int MAX_FRAC_IN  = rcf_pkg::MAX_FRAC_IN_DEF,
  parameter int MAX_FRAC_OUT = rcf_pkg::MAX_FRAC_OUT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_digit_char,
  input  logic       in_fraction,
  input  logic       in_negative,
  input  logic       in_last,
  output logic       out_valid,
  output logic [7:0] out_char,
  output logic       out_fraction,
  output logic       out_sign,
  output logic [1:0] out_status,
  output logic       out_end_of_run,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata
);
  import rcf_pkg::*;

  localparam int FW = 4 * MAX_FRAC_IN;
  localparam int JW = INT_BITS + FW + (FW + 1) + 3;

  logic [4:0] src_base_r, dst_base_r;
  logic [4:0] src_base, dst_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r <= BASE_RESET;
      dst_base_r <= BASE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_BASE: src_base_r <= cfg_wdata;
        CFG_DST_BASE: dst_base_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign src_base = clamp_base(src_base_r);
  assign dst_base = clamp_base(dst_base_r);

  logic                accept, push, pop;
  logic [INT_BITS-1:0] f_int, b_int;
  logic [FW-1:0]       f_num, b_num;
  logic [FW:0]         f_den, b_den;
  logic [1:0]          f_err, b_err;
  logic                f_neg, b_neg;
  logic [JW-1:0]       q_wdata, q_rdata;
  rcf_fifo_stat_t      q_stat;

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  rcf_front #(.INT_BITS(INT_BITS), .MAX_FRAC_IN(MAX_FRAC_IN)) u_front (
    .clk, .rst_n, .accept,
    .digit_char(in_digit_char), .frac_digit(in_fraction),
    .negative(in_negative), .last(in_last), .src_base,
    .push, .job_int(f_int), .job_num(f_num), .job_den(f_den),
    .job_err(f_err), .job_neg(f_neg)
  );

  assign q_wdata = {f_neg, f_err, f_den, f_num, f_int};

  rcf_fifo #(.WIDTH(JW), .DEPTH(2)) u_queue (
    .clk, .rst_n, .push, .wdata(q_wdata), .pop, .rdata(q_rdata), .stat(q_stat)
  );

  assign {b_neg, b_err, b_den, b_num, b_int} = q_rdata;

  rcf_back #(
    .INT_BITS(INT_BITS), .MAX_FRAC_IN(MAX_FRAC_IN), .MAX_FRAC_OUT(MAX_FRAC_OUT)
  ) u_back (
    .clk, .rst_n, .dst_base, .fifo_stat(q_stat),
    .job_int(b_int), .job_num(b_num), .job_den(b_den),
    .job_err(b_err), .job_neg(b_neg), .pop,
    .out_valid, .out_char, .out_fraction, .out_sign, .out_status, .out_end_of_run
  );

endmodule

>>> design/rcf_front.sv
// Front end: decodes digit characters and accumulates integer and fraction.
// Pushes one finished number per last digit into the job queue. Uses rcf_pkg.
module rcf_front #(
  parameter int INT_BITS    = rcf_pkg::INT_BITS_DEF,
  parameter int MAX_FRAC_IN = rcf_pkg::MAX_FRAC_IN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [7:0]                 digit_char,
  input  logic                       frac_digit,
  input  logic                       negative,
  input  logic                       last,
  input  logic [4:0]                 src_base,
  output logic                       push,
  output logic [INT_BITS-1:0]        job_int,
  output logic [4*MAX_FRAC_IN-1:0]   job_num,
  output logic [4*MAX_FRAC_IN:0]     job_den,
  output logic [1:0]                 job_err,
  output logic                       job_neg
);
  import rcf_pkg::*;

  localparam int FW = 4 * MAX_FRAC_IN;
  localparam int VW = INT_BITS + 5;
  localparam int CW = $clog2(MAX_FRAC_IN + 1);

  logic [INT_BITS-1:0] int_r, int_nxt;
  logic [FW-1:0]       num_r, num_nxt;
  logic [FW:0]         den_r, den_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]          err_r, err_nxt;

  logic [3:0]    dig;
  logic          ok;
  logic [VW-1:0] iv;

  always_comb begin
    dig = 4'd0;
    ok  = 1'b1;
    if (digit_char >= CHAR_ZERO && digit_char <= CHAR_NINE) begin
      dig = 4'(digit_char - CHAR_ZERO);
    end else if (digit_char >= CHAR_A && digit_char <= CHAR_F) begin
      dig = 4'(digit_char - CHAR_A + 8'd10);
    end else begin
      ok = 1'b0;
    end
    if (ok && {1'b0, dig} >= src_base) ok = 1'b0;

    iv = VW'(int_r) * VW'(src_base) + VW'(dig);

    int_nxt = int_r;
    num_nxt = num_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    if (!ok) begin
      if (err_r == ST_OK) err_nxt = ST_BAD_DIGIT;
    end else if (frac_digit) begin
      // drop fraction digits past the input limit
      if (cnt_r < CW'(MAX_FRAC_IN)) begin
        num_nxt = FW'(FW'(num_r) * FW'(src_base) + FW'(dig));
        den_nxt = (FW + 1)'(den_r * (FW + 1)'(src_base));
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      if (iv > VW'({INT_BITS{1'b1}})) begin
        int_nxt = {INT_BITS{1'b1}};
        if (err_r == ST_OK) err_nxt = ST_OVERFLOW;
      end else begin
        int_nxt = iv[INT_BITS-1:0];
      end
    end
  end

  assign push    = accept && last;
  assign job_int = int_nxt;
  assign job_num = num_nxt;
  assign job_den = den_nxt;
  assign job_err = err_nxt;
  assign job_neg = negative;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      int_r <= '0;
      num_r <= '0;
      den_r <= (FW + 1)'(1);
      cnt_r <= '0;
      err_r <= ST_OK;
    end else if (accept) begin
      int_r <= int_nxt;
      num_r <= num_nxt;
      den_r <= den_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

>>> design/rcf_fifo.sv
// Short job queue between the front and back ends.
// Uses rcf_pkg for the status struct.
module rcf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [WIDTH-1:0]        wdata,
  input  logic                    pop,
  output logic [WIDTH-1:0]        rdata,
  output rcf_pkg::rcf_fifo_stat_t stat
);
  import rcf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

endmodule

>>> design/rcf_back.sv
// Back end: turns one queued number into destination-base digit items.
// Bit-serial integer division, digit store, fraction by shift-subtract. Uses rcf_pkg.
module rcf_back #(
  parameter int INT_BITS     = rcf_pkg::INT_BITS_DEF,
  parameter int MAX_FRAC_IN  = rcf_pkg::MAX_FRAC_IN_DEF,
  parameter int MAX_FRAC_OUT = rcf_pkg::MAX_FRAC_OUT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [4:0]                 dst_base,
  input  rcf_pkg::rcf_fifo_stat_t    fifo_stat,
  input  logic [INT_BITS-1:0]        job_int,
  input  logic [4*MAX_FRAC_IN-1:0]   job_num,
  input  logic [4*MAX_FRAC_IN:0]     job_den,
  input  logic [1:0]                 job_err,
  input  logic                       job_neg,
  output logic                       pop,
  output logic                       out_valid,
  output logic [7:0]                 out_char,
  output logic                       out_fraction,
  output logic                       out_sign,
  output logic [1:0]                 out_status,
  output logic                       out_end_of_run
);
  import rcf_pkg::*;

  localparam int FW  = 4 * MAX_FRAC_IN;
  localparam int PW  = FW + 4;
  localparam int AW  = $clog2(INT_BITS);
  localparam int NW  = $clog2(INT_BITS + 1);
  localparam int FCW = $clog2(MAX_FRAC_OUT + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_INT_DIV, S_INT_RD, S_INT_OUT, S_FRAC_CHK, S_FRAC_MUL, S_FRAC_DIV
  } state_t;

  state_t              state_r;
  logic [INT_BITS-1:0] int_r;
  logic [3:0]          rem_r;
  logic [AW-1:0]       bit_cnt_r;
  logic [NW-1:0]       n_r;
  logic [AW-1:0]       rd_addr_r;
  logic [3:0]          rd_data_r;
  logic [FW-1:0]       r_r;
  logic [FW:0]         den_r;
  logic [PW-1:0]       prod_r;
  logic [1:0]          step_r;
  logic [3:0]          qdig_r;
  logic [FCW-1:0]      fcnt_r;
  logic                out_valid_r, out_fraction_r, out_sign_r, out_end_r;
  logic [7:0]          out_char_r;
  logic [1:0]          out_status_r;

  logic [3:0]          digit_mem [INT_BITS];

  logic [4:0]          div_t;
  logic                qbit;
  logic [3:0]          rem_new;
  logic [INT_BITS-1:0] q_new;
  logic                wr_en;
  logic [PW-1:0]       den_sh, prod_sub;
  logic                ge;
  logic [3:0]          qdig_new;
  logic                fin;

  always_comb begin
    div_t   = {rem_r, int_r[INT_BITS-1]};
    qbit    = (div_t >= dst_base);
    rem_new = qbit ? 4'(div_t - dst_base) : div_t[3:0];
    q_new   = {int_r[INT_BITS-2:0], qbit};
    wr_en   = (state_r == S_INT_DIV) && (bit_cnt_r == '0);

    den_sh   = PW'(den_r) << step_r;
    ge       = (prod_r >= den_sh);
    prod_sub = ge ? prod_r - den_sh : prod_r;
    qdig_new = qdig_r;
    qdig_new[step_r] = ge;
    fin = (prod_sub == '0) || (fcnt_r == FCW'(MAX_FRAC_OUT - 1));
  end

  assign pop = (state_r == S_IDLE) && !fifo_stat.empty;

  always_ff @(posedge clk) begin
    if (wr_en) digit_mem[n_r[AW-1:0]] <= rem_new;
    rd_data_r <= digit_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!fifo_stat.empty) begin
            int_r      <= job_int;
            r_r        <= job_num;
            den_r      <= job_den;
            rem_r      <= 4'd0;
            bit_cnt_r  <= AW'(INT_BITS - 1);
            n_r        <= '0;
            fcnt_r     <= '0;
            out_sign_r <= job_neg;
            if (job_err != ST_OK) begin
              out_valid_r    <= 1'b1;
              out_char_r     <= 8'd0;
              out_fraction_r <= 1'b0;
              out_status_r   <= job_err;
              out_end_r      <= 1'b1;
            end else begin
              state_r <= S_INT_DIV;
            end
          end
        end
        S_INT_DIV: begin
          int_r <= q_new;
          if (bit_cnt_r == '0) begin
            // digit done: restart for the next one or read back
            rem_r     <= 4'd0;
            bit_cnt_r <= AW'(INT_BITS - 1);
            n_r       <= n_r + 1'b1;
            if (q_new == '0 || n_r == NW'(INT_BITS - 1)) begin
              rd_addr_r <= n_r[AW-1:0];
              state_r   <= S_INT_RD;
            end
          end else begin
            rem_r     <= rem_new;
            bit_cnt_r <= bit_cnt_r - 1'b1;
          end
        end
        S_INT_RD: begin
          state_r <= S_INT_OUT;
        end
        S_INT_OUT: begin
          out_valid_r    <= 1'b1;
          out_char_r     <= to_char(rd_data_r);
          out_fraction_r <= 1'b0;
          out_status_r   <= ST_OK;
          out_end_r      <= 1'b0;
          if (rd_addr_r == '0) begin
            state_r <= S_FRAC_CHK;
          end else begin
            rd_addr_r <= rd_addr_r - 1'b1;
            state_r   <= S_INT_RD;
          end
        end
        S_FRAC_CHK: begin
          if (r_r == '0) begin
            out_valid_r    <= 1'b1;
            out_char_r     <= CHAR_ZERO;
            out_fraction_r <= 1'b1;
            out_status_r   <= ST_OK;
            out_end_r      <= 1'b1;
            state_r        <= S_IDLE;
          end else begin
            state_r <= S_FRAC_MUL;
          end
        end
        S_FRAC_MUL: begin
          prod_r  <= PW'(r_r) * PW'(dst_base);
          step_r  <= 2'd3;
          qdig_r  <= 4'd0;
          state_r <= S_FRAC_DIV;
        end
        S_FRAC_DIV: begin
          prod_r <= prod_sub;
          qdig_r <= qdig_new;
          if (step_r == 2'd0) begin
            out_valid_r    <= 1'b1;
            out_char_r     <= to_char(qdig_new);
            out_fraction_r <= 1'b1;
            out_status_r   <= ST_OK;
            out_end_r      <= fin;
            r_r            <= prod_sub[FW-1:0];
            fcnt_r         <= fcnt_r + 1'b1;
            state_r        <= fin ? S_IDLE : S_FRAC_MUL;
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_fraction   = out_fraction_r;
  assign out_sign       = out_sign_r;
  assign out_status     = out_status_r;
  assign out_end_of_run = out_end_r;

`ifndef SYNTHESIS
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_end_of_run && out_char == 8'd0)
    else $error("error item must be the only, final item");
  a_int_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fraction && out_status == ST_OK |-> !out_end_of_run)
    else $error("integer digit marked as end of run");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r != S_IDLE || out_valid)
    else $error("popped job did not start");
`endif

endmodule
